// File: sv/baro_sensor_compensation_defines.svh
// ---------------------------------------------------------------------------
// Barometric compensation assertion macros
// Shared concurrent checks, clocked on clk and idle while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BARO_SENSOR_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_DEFINES_SVH

// Same-cycle implication
`define BSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/bsc_pkg.sv
// ---------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the compensation pipeline.
// ---------------------------------------------------------------------------
package bsc_pkg;

    localparam int DIV_STEPS = 64;

    localparam logic [20:0] PRESS_FULL  = 21'd1048576;
    localparam logic [32:0] PRESS_OFS   = 33'd128000;
    localparam logic [12:0] PRESS_SCALE = 13'd3125;
    localparam logic [31:0] TEMP_ROUND  = 32'd128;
    localparam logic [63:0] V1_BIAS     = 64'h0000_8000_0000_0000;

    localparam logic [7:0] CFG_CAL_TEMP    = 8'd0;
    localparam logic [7:0] CFG_CAL_PRESS_A = 8'd1;
    localparam logic [7:0] CFG_CAL_PRESS_B = 8'd2;
    localparam logic [7:0] CFG_CAL_PRESS_C = 8'd3;

    typedef struct packed {
        logic [15:0] press_c;
        logic [63:0] press_b;
        logic [63:0] press_a;
        logic [47:0] temp;
    } bsc_cal_t;

    typedef struct packed {
        logic [31:0] temp;
        logic        neg;
        logic        dz;
    } bsc_side_t;

    // one divider step: partial remainder, dividend/quotient shift word, divisor
    typedef struct packed {
        logic [30:0] rem;
        logic [63:0] qn;
        logic [30:0] md;
        bsc_side_t   side;
    } bsc_div_t;

endpackage

// File: sv/bsc_front.sv
// ---------------------------------------------------------------------------
// bsc_front
// Temperature compensation and pressure coefficient stages up to the divider.
// ---------------------------------------------------------------------------
module bsc_front
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [19:0] adc_temp,
    input  logic [19:0] adc_press,
    input  bsc_cal_t    cal,
    output logic        out_valid,
    output bsc_div_t    out_div
);

    logic [9:0] valid_reg;
    logic [9:0] valid_next;

    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
    assign t1 = cal.temp[15:0];
    assign t2 = cal.temp[31:16];
    assign t3 = cal.temp[47:32];
    assign p1 = cal.press_a[15:0];
    assign p2 = cal.press_a[31:16];
    assign p3 = cal.press_a[47:32];
    assign p4 = cal.press_a[63:48];
    assign p5 = cal.press_b[15:0];
    assign p6 = cal.press_b[31:16];

    // stage 1
    logic [31:0] x;
    logic [17:0] y;
    logic [31:0] s1_xt2_reg, s1_xt2_next, s1_yy_reg, s1_yy_next;
    logic [19:0] s1_ap_reg;
    assign x = {15'd0, adc_temp[19:3]} - {15'd0, t1, 1'b0};
    assign y = {2'd0, adc_temp[19:4]} - {2'd0, t1};
    assign s1_xt2_next = $signed(x) * $signed(t2);
    assign s1_yy_next  = $signed(y) * $signed(y);

    // stage 2
    logic [31:0] yy_sh;
    logic [31:0] s2_a_reg, s2_a_next, s2_b1_reg, s2_b1_next;
    logic [19:0] s2_ap_reg;
    assign yy_sh      = $signed(s1_yy_reg) >>> 12;
    assign s2_a_next  = $signed(s1_xt2_reg) >>> 11;
    assign s2_b1_next = $signed(yy_sh) * $signed(t3);

    // stage 3: fine temperature
    logic [31:0] s3_fine_reg, s3_fine_next, b1_sh;
    logic [32:0] s3_v1_reg, s3_v1_next;
    logic [19:0] s3_ap_reg;
    assign b1_sh        = $signed(s2_b1_reg) >>> 14;
    assign s3_fine_next = s2_a_reg + b1_sh;
    assign s3_v1_next   = {s3_fine_next[31], s3_fine_next} - PRESS_OFS;

    // stage 4
    logic [31:0] f5, s4_temp_reg, s4_temp_next;
    logic [63:0] s4_vv_reg, s4_vv_next, s4_v1p5_reg, s4_v1p5_next, s4_v1p2_reg, s4_v1p2_next;
    logic [20:0] s4_pr_reg, s4_pr_next;
    assign f5           = {s3_fine_reg[29:0], 2'b00} + s3_fine_reg + TEMP_ROUND;
    assign s4_temp_next = $signed(f5) >>> 8;
    assign s4_vv_next   = $signed(s3_v1_reg) * $signed(s3_v1_reg);
    assign s4_v1p5_next = $signed(s3_v1_reg) * $signed(p5);
    assign s4_v1p2_next = $signed(s3_v1_reg) * $signed(p2);
    assign s4_pr_next   = PRESS_FULL - {1'b0, s3_ap_reg};

    // stage 5
    logic [63:0] s5_v2a_reg, s5_v2a_next, s5_v1a_reg, s5_v1a_next;
    logic [63:0] s5_v1p5_reg, s5_v1p2_reg;
    logic [31:0] s5_temp_reg;
    logic [20:0] s5_pr_reg;
    assign s5_v2a_next = $signed(s4_vv_reg) * $signed(p6);
    assign s5_v1a_next = $signed(s4_vv_reg) * $signed(p3);

    // stage 6
    logic [63:0] p4_ext, s6_v2_reg, s6_v2_next, s6_v1b_reg, s6_v1b_next, v1a_sh;
    logic [31:0] s6_temp_reg;
    logic [20:0] s6_pr_reg;
    assign p4_ext      = {{48{p4[15]}}, p4};
    assign v1a_sh      = $signed(s5_v1a_reg) >>> 8;
    assign s6_v2_next  = s5_v2a_reg + {s5_v1p5_reg[46:0], 17'd0} + {p4_ext[28:0], 35'd0};
    assign s6_v1b_next = v1a_sh + {s5_v1p2_reg[51:0], 12'd0};

    // stage 7
    logic [63:0] s7_v1s_reg, s7_v1s_next, s7_diff_reg, s7_diff_next;
    logic [31:0] s7_temp_reg;
    assign s7_v1s_next  = s6_v1b_reg + V1_BIAS;
    assign s7_diff_next = {12'd0, s6_pr_reg, 31'd0} - s6_v2_reg;

    // stage 8
    logic [63:0] s8_c_reg, s8_c_next, s8_num_reg, s8_num_next;
    logic [31:0] s8_temp_reg;
    assign s8_c_next   = $signed(s7_v1s_reg) * $signed({1'b0, p1});
    assign s8_num_next = $signed(s7_diff_reg) * $signed(PRESS_SCALE);

    // stage 9: divisor and dividend magnitude
    logic [30:0] s9_den_reg, s9_den_next;
    logic [63:0] s9_mn_reg, s9_mn_next;
    logic        s9_nsign_reg, s9_dz_reg, s9_dz_next;
    logic [31:0] s9_temp_reg;
    assign s9_den_next = s8_c_reg[63:33];
    assign s9_dz_next  = (s9_den_next == 31'd0);
    assign s9_mn_next  = s8_num_reg[63] ? (64'd0 - s8_num_reg) : s8_num_reg;

    // stage 10
    bsc_div_t s10_reg, s10_next;
    always_comb
    begin
        s10_next.rem       = '0;
        s10_next.qn        = s9_mn_reg;
        s10_next.md        = s9_den_reg[30] ? (31'd0 - s9_den_reg) : s9_den_reg;
        s10_next.side.temp = s9_temp_reg;
        s10_next.side.neg  = s9_nsign_reg ^ s9_den_reg[30];
        s10_next.side.dz   = s9_dz_reg;
    end

    assign valid_next = {valid_reg[8:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_xt2_reg   <= s1_xt2_next;
            s1_yy_reg    <= s1_yy_next;
            s1_ap_reg    <= adc_press;
            s2_a_reg     <= s2_a_next;
            s2_b1_reg    <= s2_b1_next;
            s2_ap_reg    <= s1_ap_reg;
            s3_fine_reg  <= s3_fine_next;
            s3_v1_reg    <= s3_v1_next;
            s3_ap_reg    <= s2_ap_reg;
            s4_temp_reg  <= s4_temp_next;
            s4_vv_reg    <= s4_vv_next;
            s4_v1p5_reg  <= s4_v1p5_next;
            s4_v1p2_reg  <= s4_v1p2_next;
            s4_pr_reg    <= s4_pr_next;
            s5_v2a_reg   <= s5_v2a_next;
            s5_v1a_reg   <= s5_v1a_next;
            s5_v1p5_reg  <= s4_v1p5_reg;
            s5_v1p2_reg  <= s4_v1p2_reg;
            s5_temp_reg  <= s4_temp_reg;
            s5_pr_reg    <= s4_pr_reg;
            s6_v2_reg    <= s6_v2_next;
            s6_v1b_reg   <= s6_v1b_next;
            s6_temp_reg  <= s5_temp_reg;
            s6_pr_reg    <= s5_pr_reg;
            s7_v1s_reg   <= s7_v1s_next;
            s7_diff_reg  <= s7_diff_next;
            s7_temp_reg  <= s6_temp_reg;
            s8_c_reg     <= s8_c_next;
            s8_num_reg   <= s8_num_next;
            s8_temp_reg  <= s7_temp_reg;
            s9_den_reg   <= s9_den_next;
            s9_dz_reg    <= s9_dz_next;
            s9_mn_reg    <= s9_mn_next;
            s9_nsign_reg <= s8_num_reg[63];
            s9_temp_reg  <= s8_temp_reg;
            s10_reg      <= s10_next;
        end
    end

    assign out_valid = valid_reg[9];
    assign out_div   = s10_reg;

endmodule

// File: sv/bsc_div.sv
// ---------------------------------------------------------------------------
// bsc_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module bsc_div
    import bsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  bsc_div_t in_div,
    output logic     out_valid,
    output bsc_div_t out_div
);

    logic     valid_reg [DIV_STEPS];
    bsc_div_t st_reg    [DIV_STEPS];
    bsc_div_t st_next   [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        bsc_div_t    cur;
        logic        cur_valid;
        logic [31:0] trial;
        logic        ge;

        if (i == 0)
        begin : g_first
            assign cur       = in_div;
            assign cur_valid = in_valid;
        end
        else
        begin : g_rest
            assign cur       = st_reg[i-1];
            assign cur_valid = valid_reg[i-1];
        end

        // shift the next dividend bit in and try a subtract
        assign trial = {cur.rem, cur.qn[63]};
        assign ge    = (trial >= {1'b0, cur.md});

        always_comb
        begin
            st_next[i]      = cur;
            st_next[i].rem  = ge ? 31'(trial - {1'b0, cur.md}) : trial[30:0];
            st_next[i].qn   = {cur.qn[62:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= cur_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_div   = st_reg[DIV_STEPS-1];

endmodule

// File: sv/bsc_post.sv
// ---------------------------------------------------------------------------
// bsc_post
// Quotient sign fix-up and the second-order pressure correction.
// ---------------------------------------------------------------------------
module bsc_post
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  bsc_div_t    in_div,
    input  bsc_cal_t    cal,
    output logic        out_valid,
    output logic [31:0] temp_centi,
    output logic [31:0] press_q24_8,
    output logic        div_zero
);

    logic [5:0] valid_reg;

    logic [15:0] p7, p8, p9;
    assign p7 = cal.press_b[47:32];
    assign p8 = cal.press_b[63:48];
    assign p9 = cal.press_c;

    // E1: signed quotient
    logic [63:0] e1_p_reg, e1_p_next;
    bsc_side_t   e1_side_reg;
    assign e1_p_next = in_div.side.neg ? (64'd0 - in_div.qn) : in_div.qn;

    // E2: square of p >> 13 as two 32-bit partial products
    logic [63:0] p13;
    logic [63:0] e2_pp0_reg, e2_pp0_next, e2_p8p_reg, e2_p8p_next, e2_p_reg;
    logic [31:0] e2_cross_reg, e2_cross_next;
    bsc_side_t   e2_side_reg;
    assign p13           = $signed(e1_p_reg) >>> 13;
    assign e2_pp0_next   = p13[31:0] * p13[31:0];
    assign e2_cross_next = p13[31:0] * p13[63:32];
    assign e2_p8p_next   = $signed(e1_p_reg) * $signed(p8);

    // E3
    logic [63:0] e3_sq_reg, e3_sq_next, e3_v2_reg, e3_v2_next, e3_p_reg;
    bsc_side_t   e3_side_reg;
    assign e3_sq_next = e2_pp0_reg + {e2_cross_reg[30:0], 1'b0, 32'd0};
    assign e3_v2_next = $signed(e2_p8p_reg) >>> 19;

    // E4
    logic [63:0] e4_t_reg, e4_t_next, e4_v2_reg, e4_p_reg;
    bsc_side_t   e4_side_reg;
    assign e4_t_next = $signed(e3_sq_reg) * $signed(p9);

    // E5
    logic [63:0] e5_sum_reg, e5_sum_next, t_sh;
    bsc_side_t   e5_side_reg;
    assign t_sh        = $signed(e4_t_reg) >>> 25;
    assign e5_sum_next = e4_p_reg + t_sh + e4_v2_reg;

    // E6: only the low 32 bits of the result leave the block
    logic [31:0] p7_sh, e6_press_reg, e6_press_next;
    bsc_side_t   e6_side_reg;
    assign p7_sh         = {{12{p7[15]}}, p7, 4'd0};
    assign e6_press_next = e5_side_reg.dz ? 32'd0 : (e5_sum_reg[39:8] + p7_sh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_p_reg     <= e1_p_next;
            e1_side_reg  <= in_div.side;
            e2_pp0_reg   <= e2_pp0_next;
            e2_cross_reg <= e2_cross_next;
            e2_p8p_reg   <= e2_p8p_next;
            e2_p_reg     <= e1_p_reg;
            e2_side_reg  <= e1_side_reg;
            e3_sq_reg    <= e3_sq_next;
            e3_v2_reg    <= e3_v2_next;
            e3_p_reg     <= e2_p_reg;
            e3_side_reg  <= e2_side_reg;
            e4_t_reg     <= e4_t_next;
            e4_v2_reg    <= e3_v2_reg;
            e4_p_reg     <= e3_p_reg;
            e4_side_reg  <= e3_side_reg;
            e5_sum_reg   <= e5_sum_next;
            e5_side_reg  <= e4_side_reg;
            e6_press_reg <= e6_press_next;
            e6_side_reg  <= e5_side_reg;
        end
    end

    assign out_valid   = valid_reg[5];
    assign temp_centi  = e6_side_reg.temp;
    assign press_q24_8 = e6_press_reg;
    assign div_zero    = e6_side_reg.dz;

endmodule

// File: sv/baro_sensor_compensation.sv
// ---------------------------------------------------------------------------
// baro_sensor_compensation
// Integer temperature and pressure compensation of raw barometer readings.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one item per reading pair: raw temperature and raw pressure.
//   m_* returns one item per input item, in order: temperature in 0.01 degC
//   and pressure in Q24.8 pascals; tuser flags a zero pressure divisor, in
//   which case the pressure is 0.
//   cfg_* writes the calibration words (index 0..3); it is always ready.
//   It is to be written by the user only while no item is in flight; the
//   block itself does not enforce this. Other indexes are ignored.
//   Throughput: one item per cycle while s_tready is high. Depth: 10 front
//   stages, 64 divider stages, 6 correction stages and the output register;
//   the 64-bit division, one quotient bit per stage, sets the depth.
//   Reset clears all valid bits and the calibration words to zero.
//   When the receiver stalls, the result stays in the output register and
//   the pipeline keeps moving until its last stage is also full; only then
//   does s_tready drop, so no item is lost or repeated.
// ---------------------------------------------------------------------------
`include "baro_sensor_compensation_defines.svh"

module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // adc_temp[19:0], adc_press[39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // temp_centi[31:0], press_q24_8[63:32]
    output logic [0:0]  m_tuser,     // div_zero[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_a_reg, cal_press_b_reg;
    logic [15:0] cal_press_c_reg;
    bsc_cal_t    cal;

    logic        pipe_en;
    logic        front_valid, div_valid, post_valid;
    bsc_div_t    front_div, div_out;
    logic [31:0] post_temp, post_press;
    logic        post_dz;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_temp_reg, out_press_reg;
    logic        out_dz_reg;
    logic        out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_press_c_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CAL_TEMP:    cal_temp_reg    <= cfg_data[47:0];
                CFG_CAL_PRESS_A: cal_press_a_reg <= cfg_data;
                CFG_CAL_PRESS_B: cal_press_b_reg <= cfg_data;
                CFG_CAL_PRESS_C: cal_press_c_reg <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cal.temp    = cal_temp_reg;
        cal.press_a = cal_press_a_reg;
        cal.press_b = cal_press_b_reg;
        cal.press_c = cal_press_c_reg;
    end

    // hold the whole pipeline only when both the last stage and the output are full and m_tready is low
    assign pipe_en  = !(post_valid && out_valid_reg && !m_tready);
    assign s_tready = pipe_en;

    bsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .adc_temp  (s_tdata[19:0]),
        .adc_press (s_tdata[39:20]),
        .cal       (cal),
        .out_valid (front_valid),
        .out_div   (front_div)
    );

    bsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (front_valid),
        .in_div    (front_div),
        .out_valid (div_valid),
        .out_div   (div_out)
    );

    bsc_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (pipe_en),
        .in_valid    (div_valid),
        .in_div      (div_out),
        .cal         (cal),
        .out_valid   (post_valid),
        .temp_centi  (post_temp),
        .press_q24_8 (post_press),
        .div_zero    (post_dz)
    );

    assign out_load       = post_valid && (!out_valid_reg || m_tready);
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_temp_reg  <= post_temp;
            out_press_reg <= post_press;
            out_dz_reg    <= post_dz;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_press_reg, out_temp_reg};
    assign m_tuser  = out_dz_reg;

    `BSC_ASSERT_NOW(a_stall_blocks_input, post_valid && out_valid_reg && !m_tready, !s_tready, "pipeline advanced while output full")
    `BSC_ASSERT_NOW(a_div_zero_press, m_tvalid && m_tuser[0], m_tdata[63:32] == 32'd0, "pressure not zero on zero divisor")
    `BSC_ASSERT_NEXT(a_cfg_press_c, cfg_valid && cfg_ready && cfg_index == CFG_CAL_PRESS_C, cal_press_c_reg == $past(cfg_data[15:0]), "P9 write lost")

endmodule

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// Barometric compensation testbench
// Drives raw reading pairs through the pipeline under several calibration
// sets, predicts each result in 32/64-bit wrapping arithmetic and checks it
// field by field in order, with random bursts, output stalls and a watchdog.
// ---------------------------------------------------------------------------
module testbench
    import bsc_pkg::*;
();

    localparam int LATENCY   = 81;
    localparam int IDLE_MAX  = 20000;

    typedef struct {
        logic [31:0] temp_centi;
        logic [31:0] press_q24_8;
        logic        div_zero;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [63:0] cfg_data;

    int error_count;
    int idle_cycles;
    bit hold_off;
    bit stall_mode;

    // calibration copy used by the predictor
    logic [47:0] cal_temp;
    logic [63:0] cal_press_a;
    logic [63:0] cal_press_b;
    logic [15:0] cal_press_c;

    baro_sensor_compensation dut (.*);

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic reading_t compensate(input logic [19:0] at, input logic [19:0] ap);
        reading_t r;
        logic signed [31:0] t1, t2, t3, x, a, y, b, fine;
        logic signed [63:0] f64, v1, v2, p, num;
        logic [63:0] mn, md, q;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        x = {3'd0, at[19:3]} - (t1 << 1);
        a = (x * t2) >>> 11;
        y = {4'd0, at[19:4]} - t1;
        b = (((y * y) >>> 12) * t3) >>> 14;
        fine = a + b;
        r.temp_centi = (fine * 32'sd5 + 32'sd128) >>> 8;
        f64 = {{32{fine[31]}}, fine};
        v1 = f64 - 64'sd128000;
        v2 = v1 * v1 * $signed(sx16(cal_press_b[31:16]));
        v2 = v2 + ((v1 * $signed(sx16(cal_press_b[15:0]))) << 17);
        v2 = v2 + ($signed(sx16(cal_press_a[63:48])) << 35);
        v1 = ((v1 * v1 * $signed(sx16(cal_press_a[47:32]))) >>> 8)
           + ((v1 * $signed(sx16(cal_press_a[31:16]))) << 12);
        v1 = (((64'sd1 << 47) + v1) * $signed({48'd0, cal_press_a[15:0]})) >>> 33;
        if (v1 == 0)
        begin
            r.press_q24_8 = '0;
            r.div_zero = 1'b1;
            return r;
        end
        p = 64'sd1048576 - $signed({44'd0, ap});
        num = ((p << 31) - v2) * 64'sd3125;
        mn = num[63] ? -num : num;
        md = v1[63] ? -v1 : v1;
        q = mn / md;
        p = (num[63] != v1[63]) ? -q : q;
        v1 = ($signed(sx16(cal_press_c)) * (p >>> 13) * (p >>> 13)) >>> 25;
        v2 = ($signed(sx16(cal_press_b[63:48])) * p) >>> 19;
        p = ((p + v1 + v2) >>> 8) + ($signed(sx16(cal_press_b[47:32])) << 4);
        r.press_q24_8 = p[31:0];
        r.div_zero = 1'b0;
        return r;
    endfunction

    class reading_scoreboard;
        reading_t pending[$];

        function void note_reading(input logic [39:0] data);
            pending.push_back(compensate(data[19:0], data[39:20]));
        endfunction

        task check_result(input logic [63:0] data, input logic dz);
            reading_t e;
            if (pending.size() == 0)
            begin
                report("unexpected result", data, 64'd0);
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.temp_centi)
                report("temp_centi", {32'd0, data[31:0]}, {32'd0, e.temp_centi});
            if (data[63:32] !== e.press_q24_8)
                report("press_q24_8", {32'd0, data[63:32]}, {32'd0, e.press_q24_8});
            if (dz !== e.div_zero)
                report("div_zero", {63'd0, dz}, {63'd0, e.div_zero});
        endtask
    endclass

    reading_scoreboard sb = new();

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_reading(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver: own stall pattern, a long hold-off on request, or always ready
    initial
    begin
        int k;
        m_tready = 1'b0;
        k = 0;
        forever
        begin
            @(negedge clk);
            k++;
            if (hold_off)
                m_tready <= 1'b0;
            else if (stall_mode)
                m_tready <= (k % 7 < 4) && ($urandom_range(0, 3) != 0);
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CAL_TEMP:    cal_temp    = val[47:0];
            CFG_CAL_PRESS_A: cal_press_a = val;
            CFG_CAL_PRESS_B: cal_press_b = val;
            CFG_CAL_PRESS_C: cal_press_c = val[15:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic calibrate(input logic [47:0] ct, input logic [63:0] pa,
                             input logic [63:0] pb, input logic [15:0] pc);
        drain();
        write_reg(CFG_CAL_TEMP, {16'hdead, ct});
        write_reg(CFG_CAL_PRESS_A, pa);
        write_reg(CFG_CAL_PRESS_B, pb);
        write_reg(CFG_CAL_PRESS_C, {48'hffff_0000_1234, pc});
    endtask

    // offer one item; keep valid high if the next one follows at once
    task automatic send_reading(input logic [19:0] at, input logic [19:0] ap, input bit gap);
        s_tdata  <= {ap, at};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (gap)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic random_burst(input int n, input bit typical);
        int left;
        left = n;
        while (left > 0)
        begin
            int len;
            len = $urandom_range(1, 12);
            for (int i = 0; i < len && left > 0; i++, left--)
            begin
                if (typical && $urandom_range(0, 4) != 0)
                    send_reading(20'($urandom_range(400000, 600000)),
                                 20'($urandom_range(250000, 450000)), 1'b0);
                else
                    send_reading(20'($urandom), 20'($urandom), 1'b0);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        logic [47:0] typ_t;
        logic [63:0] typ_a, typ_b;
        error_count = 0;
        idle_cycles = 0;
        hold_off    = 1'b0;
        stall_mode  = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cal_temp = '0; cal_press_a = '0; cal_press_b = '0; cal_press_c = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // reset calibration: divisor is zero, pressure forced to 0
        send_reading(20'd0, 20'd0, 1'b1);
        send_reading(20'hfffff, 20'hfffff, 1'b1);

        // typical factory calibration
        typ_t = {16'hfc18, 16'h6a5c, 16'h6e7e};
        typ_a = {16'h0afd, 16'hd0d0, 16'hd6a6, 16'h8e84};
        typ_b = {16'hc6f8, 16'h3c70, 16'hfff9, 16'h008c};
        calibrate(typ_t, typ_a, typ_b, 16'h1770);
        write_reg(8'd9, 64'hffff_ffff_ffff_ffff); // ignored index
        send_reading(20'd519888, 20'd415148, 1'b1);
        send_reading(20'd0, 20'd0, 1'b1);
        send_reading(20'hfffff, 20'hfffff, 1'b0);
        send_reading(20'hfffff, 20'd0, 1'b0);
        send_reading(20'd0, 20'hfffff, 1'b0);
        send_reading(20'h55555, 20'haaaaa, 1'b0);
        send_reading(20'haaaaa, 20'h55555, 1'b1);
        send_reading(20'd524288, 20'd524288, 1'b1);

        // extremes of the calibration words
        calibrate('1, '1, '1, 16'hffff);
        send_reading(20'd0, 20'd0, 1'b0);
        send_reading(20'hfffff, 20'hfffff, 1'b0);
        send_reading(20'h80000, 20'h12345, 1'b1);
        calibrate({16'h7fff, 16'h8000, 16'hffff}, {16'h7fff, 16'h8000, 16'h7fff, 16'hffff},
                  {16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 16'h8000);
        send_reading(20'd0, 20'hfffff, 1'b0);
        send_reading(20'hfffff, 20'd0, 1'b0);
        send_reading(20'd300000, 20'd300000, 1'b1);
        calibrate({16'h8000, 16'h7fff, 16'h0000}, {16'h8000, 16'h7fff, 16'h8000, 16'h0001},
                  {16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 16'h7fff);
        send_reading(20'd12345, 20'd0, 1'b0);
        send_reading(20'hfffff, 20'hfffff, 1'b1);

        // typical calibration, random readings, with stalls
        calibrate(typ_t, typ_a, typ_b, 16'h1770);
        stall_mode = 1'b1;
        random_burst(200, 1'b1);

        // long receiver hold-off while the sender keeps offering items
        fork
        begin
            hold_off = 1'b1;
            repeat (300) @(negedge clk);
            hold_off = 1'b0;
        end
        random_burst(150, 1'b1);
        join

        // random calibration sets, one of them with P1 = 0
        for (int s = 0; s < 4; s++)
        begin
            calibrate(48'({$urandom, $urandom}), {$urandom, $urandom},
                      {$urandom, $urandom}, 16'($urandom));
            if (s == 1)
                write_reg(CFG_CAL_PRESS_A, {cal_press_a[63:16], 16'd0});
            stall_mode = (s % 2 == 0);
            random_burst(60, 1'b0);
        end

        drain();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
